// ===== design/prrtp_pkg.sv =====
package prrtp_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int PID_BITS   = 16;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
  localparam int DEAD_W     = 5;
  localparam logic [DEAD_W-1:0] DEAD_MAX = '1;

  localparam logic [1:0] PRI_LOW    = 2'd0;
  localparam logic [1:0] PRI_NORMAL = 2'd1;
  localparam logic [1:0] PRI_HIGH   = 2'd2;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;
  localparam logic [1:0] ST_DEAD    = 2'd3;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_KILL  = 3'd2;
  localparam logic [2:0] OP_BLOCK = 3'd3;
  localparam logic [2:0] OP_READY = 3'd4;
  localparam logic [2:0] OP_WAKE  = 3'd5;

  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_IGNORED  = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NO_CUR   = 2'd3;

  typedef struct packed {
    logic [PID_BITS-1:0] pid;
    logic [1:0]          prio;
    logic [1:0]          state;
    logic                started;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } tbl_wr_t;

endpackage

// ===== design/prrtp_table.sv =====
module prrtp_table
  import prrtp_pkg::*;
(
  input  logic              clk,
  input  tbl_wr_t           wr,
  input  logic [SLOT_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t slots [TASK_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      slots[wr.addr] <= wr.data;
    end
  end

  assign rd_data = slots[rd_addr];

endmodule

// ===== design/priority_round_robin_task_picker.sv =====
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | op, pid, priority_req, initial_state
// out     | output    | out_valid/out_ready  | status, run_valid, run_slot, run_pid,
//         |           |                      | switched, removed, removed_pid,
//         |           |                      | count_now, dead_now
// cfg     | input     | cfg_write            | cfg_data (scheduler enable)
//
// A sequencer walks the task table through one read port, one slot a cycle.
// Add writes one new slot and kill, block and ready rewrite the current one;
// wake scans the table for the pid. A tick may run one scan to find a dead
// entry, the shift of the table, and up to four round-robin scans.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register while the next request is taken.
// Reset (rst, synchronous) empties the table and clears the enable.
module priority_round_robin_task_picker
  import prrtp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          op,
  input  logic [PID_BITS-1:0] pid,
  input  logic [1:0]          priority_req,
  input  logic [1:0]          initial_state,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic                run_valid,
  output logic [SLOT_W-1:0]   run_slot,
  output logic [PID_BITS-1:0] run_pid,
  output logic                switched,
  output logic                removed,
  output logic [PID_BITS-1:0] removed_pid,
  output logic [CNT_W-1:0]    count_now,
  output logic [DEAD_W-1:0]   dead_now
);

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_REM_SCAN, S_REM_SHIFT, S_PICK_INIT, S_PICK, S_WAKE, S_REPORT
  } fsm_t;

  fsm_t state;

  logic                enable;
  logic [CNT_W-1:0]    occupied;
  logic [DEAD_W-1:0]   dead_total;
  logic [SLOT_W-1:0]   cur_slot;
  logic                cur_valid;

  logic [2:0]          op_r;
  logic [PID_BITS-1:0] pid_r;
  logic [1:0]          prio_r;
  logic [1:0]          ist_r;

  logic [1:0]          stat_r;
  logic                sw_r;
  logic                rem_r;
  logic [PID_BITS-1:0] rem_pid_r;
  logic [SLOT_W-1:0]   victim;
  logic [SLOT_W-1:0]   ptr;
  logic [CNT_W-1:0]    cnt;
  logic [1:0]          pass;

  tbl_wr_t             wr;
  logic [SLOT_W-1:0]   rd_addr;
  entry_t              rd;

  logic                cv_now;
  logic [CNT_W-1:0]    base;
  logic [SLOT_W-1:0]   start;
  logic [SLOT_W-1:0]   ptr_adv;
  logic                last;
  logic                shift_more;
  logic [1:0]          tick_st;
  logic                hit;

  prrtp_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd)
  );

  assign in_ready = (state == S_IDLE);

  // A current slot beyond the table end counts as no current task.
  assign cv_now     = cur_valid && ({1'b0, cur_slot} < occupied);
  assign base       = cv_now ? ({1'b0, cur_slot} + CNT_W'(1)) : '0;
  assign start      = (base >= occupied) ? '0 : base[SLOT_W-1:0];
  assign last       = (({1'b0, ptr} + CNT_W'(1)) == occupied);
  assign ptr_adv    = last ? '0 : ptr + SLOT_W'(1);
  assign shift_more = (({1'b0, ptr} + CNT_W'(1)) < occupied);
  assign tick_st    = (rd.started && rd.state == ST_RUNNING) ? ST_READY : rd.state;

  always_comb begin
    case (pass)
      2'd0:    hit = (rd.prio == PRI_HIGH);
      2'd1:    hit = (rd.state == ST_BLOCKED) || (rd.state == ST_DEAD);
      2'd2:    hit = (rd.prio == PRI_NORMAL) && (rd.state == ST_READY);
      default: hit = (rd.prio == PRI_LOW);
    endcase
  end

  always_comb begin
    case (state)
      S_REM_SCAN, S_PICK, S_WAKE: rd_addr = ptr;
      S_REM_SHIFT:                rd_addr = shift_more ? ptr + SLOT_W'(1) : ptr;
      default:                    rd_addr = cur_slot;
    endcase
  end

  always_comb begin
    wr = '0;
    case (state)
      S_DISPATCH: begin
        if (op_r == OP_ADD) begin
          wr.en   = (occupied < CNT_W'(TASK_SLOTS));
          wr.addr = occupied[SLOT_W-1:0];
          wr.data = '{pid: pid_r, prio: prio_r, state: ist_r, started: 1'b0};
        end else begin
          wr.addr = cur_slot;
          wr.data = rd;
          case (op_r)
            OP_TICK: begin
              wr.en = cv_now && (occupied != '0) && enable;
              wr.data.state   = tick_st;
              wr.data.started = 1'b1;
            end
            OP_KILL: begin
              wr.en = cv_now;
              wr.data.state = ST_DEAD;
            end
            OP_BLOCK: begin
              wr.en = cv_now;
              wr.data.state = ST_BLOCKED;
            end
            OP_READY: begin
              wr.en = cv_now;
              wr.data.state = ST_READY;
            end
            default: wr.en = 1'b0;
          endcase
        end
      end
      S_REM_SHIFT: begin
        wr.en   = shift_more;
        wr.addr = ptr;
        wr.data = rd;
      end
      S_PICK: begin
        wr.en   = hit && rd.state != ST_BLOCKED && rd.state != ST_DEAD;
        wr.addr = ptr;
        wr.data = rd;
        wr.data.state = ST_RUNNING;
      end
      S_WAKE: begin
        wr.en   = (rd.pid == pid_r);
        wr.addr = ptr;
        wr.data = rd;
        wr.data.state = ST_READY;
      end
      default: wr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      enable     <= 1'b0;
      occupied   <= '0;
      dead_total <= '0;
      cur_slot   <= '0;
      cur_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        enable <= cfg_data;
      end
      if (out_valid && out_ready && state != S_REPORT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r      <= op;
            pid_r     <= pid;
            prio_r    <= priority_req;
            ist_r     <= initial_state;
            stat_r    <= STAT_DONE;
            sw_r      <= 1'b0;
            rem_r     <= 1'b0;
            rem_pid_r <= '0;
            state     <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (!cv_now && op_r != OP_ADD) begin
            cur_valid <= 1'b0;
            cur_slot  <= '0;
          end
          case (op_r)
            OP_TICK: begin
              if (!cv_now || occupied == '0 || !enable) begin
                stat_r <= STAT_IGNORED;
                state  <= S_REPORT;
              end else if ((tick_st == ST_DEAD || tick_st == ST_BLOCKED) &&
                           dead_total != '0) begin
                if (occupied == CNT_W'(1) && tick_st == ST_DEAD &&
                    dead_total == DEAD_W'(1)) begin
                  // Last task is the only dead one: the table empties.
                  rem_r      <= 1'b1;
                  rem_pid_r  <= rd.pid;
                  occupied   <= '0;
                  dead_total <= '0;
                  cur_valid  <= 1'b0;
                  cur_slot   <= '0;
                  state      <= S_PICK_INIT;
                end else begin
                  ptr   <= start;
                  cnt   <= '0;
                  state <= S_REM_SCAN;
                end
              end else begin
                state <= S_PICK_INIT;
              end
            end
            OP_ADD: begin
              state <= S_REPORT;
              if (!cv_now) begin
                cur_slot  <= '0;
                cur_valid <= (occupied < CNT_W'(TASK_SLOTS));
              end
              if (occupied >= CNT_W'(TASK_SLOTS)) begin
                stat_r <= STAT_FULL;
              end else begin
                occupied <= occupied + CNT_W'(1);
              end
            end
            OP_KILL, OP_BLOCK, OP_READY: begin
              state <= S_REPORT;
              if (!cv_now) begin
                stat_r <= STAT_NO_CUR;
              end else if (op_r == OP_KILL) begin
                if (rd.state != ST_DEAD && dead_total < DEAD_MAX) begin
                  dead_total <= dead_total + DEAD_W'(1);
                end
              end else if (op_r == OP_READY) begin
                if (rd.state == ST_DEAD && dead_total != '0) begin
                  dead_total <= dead_total - DEAD_W'(1);
                end
              end
            end
            OP_WAKE: begin
              ptr   <= '0;
              state <= (occupied != '0) ? S_WAKE : S_REPORT;
            end
            default: state <= S_REPORT;
          endcase
        end
        S_REM_SCAN: begin
          if (rd.state == ST_DEAD) begin
            victim    <= ptr;
            rem_r     <= 1'b1;
            rem_pid_r <= rd.pid;
            state     <= S_REM_SHIFT;
          end else if (cnt + CNT_W'(1) == occupied) begin
            state <= S_PICK_INIT;
          end else begin
            ptr <= ptr_adv;
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_REM_SHIFT: begin
          if (shift_more) begin
            ptr <= ptr + SLOT_W'(1);
          end else begin
            occupied <= occupied - CNT_W'(1);
            if (dead_total != '0) begin
              dead_total <= dead_total - DEAD_W'(1);
            end
            if (cur_valid) begin
              if (victim < cur_slot) begin
                cur_slot <= cur_slot - SLOT_W'(1);
              end else if (victim == cur_slot) begin
                cur_valid <= 1'b0;
                cur_slot  <= '0;
              end
            end
            state <= S_PICK_INIT;
          end
        end
        S_PICK_INIT: begin
          ptr   <= start;
          cnt   <= '0;
          pass  <= '0;
          state <= (occupied == '0) ? S_REPORT : S_PICK;
        end
        S_PICK: begin
          if (hit) begin
            if (rd.state != ST_BLOCKED && rd.state != ST_DEAD &&
                (!cv_now || ptr != cur_slot)) begin
              cur_slot  <= ptr;
              cur_valid <= 1'b1;
              sw_r      <= 1'b1;
            end
            state <= S_REPORT;
          end else if (cnt + CNT_W'(1) == occupied) begin
            ptr <= start;
            cnt <= '0;
            if (pass == 2'd3) begin
              state <= S_REPORT;
            end else if (pass == 2'd0 && dead_total == '0) begin
              pass <= 2'd2;
            end else begin
              pass <= pass + 2'd1;
            end
          end else begin
            ptr <= ptr_adv;
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_WAKE: begin
          if (rd.pid == pid_r || last) begin
            state <= S_REPORT;
          end else begin
            ptr <= ptr + SLOT_W'(1);
          end
        end
        S_REPORT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= stat_r;
            run_valid   <= cv_now;
            run_slot    <= cv_now ? cur_slot : '0;
            run_pid     <= cv_now ? rd.pid : '0;
            switched    <= sw_r;
            removed     <= rem_r;
            removed_pid <= rem_pid_r;
            count_now   <= occupied;
            dead_now    <= dead_total;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupied <= CNT_W'(TASK_SLOTS))
    else $error("task count exceeds table size");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !wr.en)
    else $error("table written while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DISPATCH))
    else $error("accepted request not dispatched");

  a_switch_has_cur: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPORT && sw_r) |-> cur_valid)
    else $error("switch reported with no current task");

endmodule

// ===== sim/priority_round_robin_task_picker_checker.sv =====
`timescale 1ns / 1ps
module priority_round_robin_task_picker_checker
  import prrtp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [2:0]          op,
  input  logic [PID_BITS-1:0] pid,
  input  logic [1:0]          priority_req,
  input  logic [1:0]          initial_state,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [1:0]          status,
  input  logic                run_valid,
  input  logic [SLOT_W-1:0]   run_slot,
  input  logic [PID_BITS-1:0] run_pid,
  input  logic                switched,
  input  logic                removed,
  input  logic [PID_BITS-1:0] removed_pid,
  input  logic [CNT_W-1:0]    count_now,
  input  logic [DEAD_W-1:0]   dead_now,
  output int                  fail_count,
  output int                  pending_count
);

  typedef struct packed {
    logic [1:0]          status;
    logic                run_valid;
    logic [SLOT_W-1:0]   run_slot;
    logic [PID_BITS-1:0] run_pid;
    logic                switched;
    logic                removed;
    logic [PID_BITS-1:0] removed_pid;
    logic [CNT_W-1:0]    count_now;
    logic [DEAD_W-1:0]   dead_now;
  } outcome_t;

  logic [PID_BITS-1:0] t_pid [TASK_SLOTS];
  logic [1:0]          t_prio [TASK_SLOTS];
  logic [1:0]          t_state [TASK_SLOTS];
  logic                t_started [TASK_SLOTS];
  int                  n_tasks;
  int                  n_dead;
  int                  cur;
  bit                  cur_ok;
  bit                  sched_on;
  outcome_t            expected_outcomes[$];

  assign pending_count = expected_outcomes.size();

  function automatic int ring_slot(int i);
    int base;
    base = cur_ok ? cur + 1 : 0;
    if (n_tasks == 0) return 0;
    return (base + i - 1) % n_tasks;
  endfunction

  function automatic bit drop_dead(output logic [PID_BITS-1:0] gone);
    int victim;
    int k;
    victim = -1;
    gone = '0;
    if (n_tasks == 1 && t_state[0] == ST_DEAD && n_dead == 1) begin
      gone = t_pid[0];
      n_tasks = 0;
      n_dead = 0;
      cur_ok = 0;
      cur = 0;
      return 1;
    end
    for (int i = 1; i <= n_tasks; i++) begin
      k = ring_slot(i);
      if (t_state[k] == ST_DEAD) begin
        victim = k;
        break;
      end
    end
    if (victim < 0) return 0;
    gone = t_pid[victim];
    for (k = victim; k + 1 < n_tasks; k++) begin
      t_pid[k] = t_pid[k+1];
      t_prio[k] = t_prio[k+1];
      t_state[k] = t_state[k+1];
      t_started[k] = t_started[k+1];
    end
    n_tasks--;
    if (n_dead > 0) n_dead--;
    if (cur_ok) begin
      if (victim < cur) cur--;
      else if (victim == cur) begin
        cur_ok = 0;
        cur = 0;
      end
    end
    return 1;
  endfunction

  function automatic bit choose_next(output int slot);
    int k;
    bit hit;
    slot = 0;
    for (int pass = 0; pass < 4; pass++) begin
      if (pass == 1 && n_dead == 0) continue;
      for (int i = 1; i <= n_tasks; i++) begin
        k = ring_slot(i);
        case (pass)
          0: hit = t_prio[k] == PRI_HIGH;
          1: hit = t_state[k] == ST_BLOCKED || t_state[k] == ST_DEAD;
          2: hit = t_prio[k] == PRI_NORMAL && t_state[k] == ST_READY;
          default: hit = t_prio[k] == PRI_LOW;
        endcase
        if (hit) begin
          slot = k;
          return 1;
        end
      end
    end
    return 0;
  endfunction

  function automatic outcome_t schedule_event(logic [2:0] o, logic [PID_BITS-1:0] p,
                                              logic [1:0] pr, logic [1:0] ist);
    outcome_t r;
    int c;
    int nxt;
    logic [PID_BITS-1:0] gone;
    r = '0;
    r.status = STAT_DONE;
    if (cur_ok && cur >= n_tasks) begin
      cur_ok = 0;
      cur = 0;
    end
    if (o == OP_TICK) begin
      if (!cur_ok || n_tasks == 0 || !sched_on) r.status = STAT_IGNORED;
      else begin
        c = cur;
        if (t_started[c] && t_state[c] == ST_RUNNING) t_state[c] = ST_READY;
        t_started[c] = 1;
        if ((t_state[c] == ST_DEAD || t_state[c] == ST_BLOCKED) && n_dead > 0)
          if (drop_dead(gone)) begin
            r.removed = 1;
            r.removed_pid = gone;
          end
        if (choose_next(nxt) && t_state[nxt] != ST_BLOCKED && t_state[nxt] != ST_DEAD) begin
          t_state[nxt] = ST_RUNNING;
          if (!cur_ok || nxt != cur) begin
            cur = nxt;
            cur_ok = 1;
            r.switched = 1;
          end
        end
      end
    end else if (o == OP_ADD) begin
      if (n_tasks >= TASK_SLOTS) r.status = STAT_FULL;
      else begin
        t_pid[n_tasks] = p;
        t_prio[n_tasks] = pr;
        t_state[n_tasks] = ist;
        t_started[n_tasks] = 0;
        n_tasks++;
        if (!cur_ok) begin
          cur = 0;
          cur_ok = 1;
        end
      end
    end else if (o == OP_KILL || o == OP_BLOCK || o == OP_READY) begin
      if (!cur_ok) r.status = STAT_NO_CUR;
      else if (o == OP_KILL) begin
        if (t_state[cur] != ST_DEAD) begin
          t_state[cur] = ST_DEAD;
          if (n_dead < DEAD_MAX) n_dead++;
        end
      end else if (o == OP_BLOCK) t_state[cur] = ST_BLOCKED;
      else begin
        if (t_state[cur] == ST_DEAD && n_dead > 0) n_dead--;
        t_state[cur] = ST_READY;
      end
    end else if (o == OP_WAKE) begin
      for (int k = 0; k < n_tasks; k++)
        if (t_pid[k] == p) begin
          t_state[k] = ST_READY;
          break;
        end
    end
    r.run_valid = cur_ok;
    r.run_slot = cur_ok ? cur[SLOT_W-1:0] : '0;
    r.run_pid = cur_ok ? t_pid[cur] : '0;
    r.count_now = n_tasks[CNT_W-1:0];
    r.dead_now = n_dead[DEAD_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  outcome_t got;
  outcome_t want;

  always @(posedge clk) begin
    if (rst) begin
      n_tasks = 0;
      n_dead = 0;
      cur = 0;
      cur_ok = 0;
      sched_on = 0;
      fail_count = 0;
      expected_outcomes.delete();
    end else begin
      if (cfg_write) sched_on = cfg_data;
      if (in_valid && in_ready)
        expected_outcomes.push_back(schedule_event(op, pid, priority_req, initial_state));
      if (out_valid && out_ready) begin
        got = '{status, run_valid, run_slot, run_pid, switched, removed, removed_pid,
                count_now, dead_now};
        if (expected_outcomes.size() == 0) report_mismatch("result with no request pending");
        else begin
          want = expected_outcomes.pop_front();
          if (got.status != want.status) report_mismatch($sformatf("status %0d want %0d",
            got.status, want.status));
          if (got.run_valid != want.run_valid) report_mismatch("run_valid");
          if (got.run_slot != want.run_slot) report_mismatch($sformatf("run_slot %0d want %0d",
            got.run_slot, want.run_slot));
          if (got.run_pid != want.run_pid) report_mismatch("run_pid");
          if (got.switched != want.switched) report_mismatch("switched");
          if (got.removed != want.removed) report_mismatch("removed");
          if (got.removed_pid != want.removed_pid) report_mismatch("removed_pid");
          if (got.count_now != want.count_now) report_mismatch("count_now");
          if (got.dead_now != want.dead_now) report_mismatch("dead_now");
        end
      end
    end
  end

endmodule

// ===== sim/priority_round_robin_task_picker_tb.sv =====
`timescale 1ns / 1ps
module priority_round_robin_task_picker_tb;
  import prrtp_pkg::*;

  logic                clk = 0;
  logic                rst = 1;
  logic                cfg_write = 0;
  logic                cfg_data = 0;
  logic                in_valid = 0;
  logic                in_ready;
  logic [2:0]          op = OP_TICK;
  logic [PID_BITS-1:0] pid = '0;
  logic [1:0]          priority_req = PRI_LOW;
  logic [1:0]          initial_state = ST_READY;
  logic                out_valid;
  logic                out_ready = 0;
  logic [1:0]          status;
  logic                run_valid;
  logic [SLOT_W-1:0]   run_slot;
  logic [PID_BITS-1:0] run_pid;
  logic                switched;
  logic                removed;
  logic [PID_BITS-1:0] removed_pid;
  logic [CNT_W-1:0]    count_now;
  logic [DEAD_W-1:0]   dead_now;
  int                  fail_count;
  int                  pending_count;
  int                  cycle_count = 0;
  bit                  calm = 0;
  logic [PID_BITS-1:0] used_pids[$];

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  priority_round_robin_task_picker u_top (.*);

  priority_round_robin_task_picker_checker u_chk (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("** priority_round_robin_task_picker: FAILED **");
      $finish;
    end
  end

  // The result side stalls in random bursts until the quiet tail of the run.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
    end
  end

  task automatic set_enable(bit v);
    cfg_write <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Valid stays high after an accepted request so the next one can follow
  // without a gap; it drops only for an idle burst or a drain.
  task automatic send_request(logic [2:0] o, logic [PID_BITS-1:0] p, logic [1:0] pr,
                              logic [1:0] st);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 8);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    op <= o;
    pid <= p;
    priority_req <= pr;
    initial_state <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic random_request();
    int r;
    logic [PID_BITS-1:0] p;
    r = $urandom_range(0, 99);
    p = (used_pids.size() > 0 && $urandom_range(0, 1)) ?
        used_pids[$urandom_range(0, used_pids.size() - 1)] : PID_BITS'($urandom);
    if (r < 30) send_request(OP_TICK, p, 2'($urandom), 2'($urandom));
    else if (r < 50) begin
      used_pids.push_back(p);
      send_request(OP_ADD, p, 2'($urandom), 2'($urandom));
    end else if (r < 62) send_request(OP_KILL, p, 2'($urandom), 2'($urandom));
    else if (r < 72) send_request(OP_BLOCK, p, 2'($urandom), 2'($urandom));
    else if (r < 82) send_request(OP_READY, p, 2'($urandom), 2'($urandom));
    else if (r < 94) send_request(OP_WAKE, p, 2'($urandom), 2'($urandom));
    else send_request(3'($urandom_range(6, 7)), p, 2'($urandom), 2'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // No current task yet: tick ignored and current-task events flagged.
    send_request(OP_TICK, '0, PRI_LOW, ST_READY);
    send_request(OP_KILL, '0, PRI_LOW, ST_READY);
    send_request(OP_BLOCK, '0, PRI_LOW, ST_READY);
    send_request(OP_READY, '0, PRI_LOW, ST_READY);
    send_request(OP_WAKE, '1, PRI_LOW, ST_READY);
    send_request(OP_ADD, '1, PRI_HIGH, ST_RUNNING);
    send_request(OP_TICK, '0, PRI_LOW, ST_READY);
    drain();
    set_enable(1);
    for (int i = 0; i < 16; i++)
      send_request(OP_ADD, PID_BITS'(i), 2'(i % 4), 2'(i / 4));
    send_request(OP_ADD, '0, PRI_HIGH, ST_DEAD);
    send_request(OP_TICK, '0, PRI_LOW, ST_READY);
    send_request(OP_KILL, '0, PRI_LOW, ST_READY);
    send_request(OP_TICK, '0, PRI_LOW, ST_READY);
    send_request(OP_WAKE, PID_BITS'(10), PRI_LOW, ST_READY);
    send_request(OP_TICK, '0, PRI_LOW, ST_READY);
    for (int ph = 0; ph < 5; ph++) begin
      for (int i = 0; i < 100; i++) begin
        if (ph == 4 && i == 60) calm = 1;
        random_request();
      end
      drain();
      set_enable(ph != 1);
    end
    drain();
    if (fail_count == 0) $display("** priority_round_robin_task_picker: PASSED **");
    else $display("** priority_round_robin_task_picker: FAILED **");
    $finish;
  end

endmodule
